### sv/sbe_pkg.sv
// shared types and constants of the stack bytecode executor
package sbe_pkg;

    // input item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EXEC  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_FAULT   = 3'd2;
    localparam logic [2:0] ST_SYSCALL = 3'd3;
    localparam logic [2:0] ST_IDLE    = 3'd4;
    localparam logic [2:0] ST_BADSIG  = 3'd5;

    // opcodes
    localparam logic [7:0] OP_HALT  = 8'h00;
    localparam logic [7:0] OP_NOP   = 8'h01;
    localparam logic [7:0] OP_PUSH  = 8'h02;
    localparam logic [7:0] OP_POP   = 8'h04;
    localparam logic [7:0] OP_DUP   = 8'h05;
    localparam logic [7:0] OP_SWAP  = 8'h06;
    localparam logic [7:0] OP_ADD   = 8'h10;
    localparam logic [7:0] OP_SUB   = 8'h11;
    localparam logic [7:0] OP_MUL   = 8'h12;
    localparam logic [7:0] OP_DIV   = 8'h13;
    localparam logic [7:0] OP_MOD   = 8'h14;
    localparam logic [7:0] OP_CMP   = 8'h20;
    localparam logic [7:0] OP_EQ    = 8'h21;
    localparam logic [7:0] OP_NEQ   = 8'h22;
    localparam logic [7:0] OP_GT    = 8'h23;
    localparam logic [7:0] OP_LT    = 8'h24;
    localparam logic [7:0] OP_JMP   = 8'h30;
    localparam logic [7:0] OP_JZ    = 8'h31;
    localparam logic [7:0] OP_JNZ   = 8'h32;
    localparam logic [7:0] OP_CALL  = 8'h33;
    localparam logic [7:0] OP_RET   = 8'h34;
    localparam logic [7:0] OP_LOAD  = 8'h40;
    localparam logic [7:0] OP_STORE = 8'h41;
    localparam logic [7:0] OP_SYS   = 8'h50;
    localparam logic [7:0] OP_BRK   = 8'h51;

    // program signature at addresses 0..3
    localparam logic [7:0] SIG0 = 8'h4E;
    localparam logic [7:0] SIG1 = 8'h56;
    localparam logic [7:0] SIG2 = 8'h4D;
    localparam logic [7:0] SIG3 = 8'h30;

    // push source select
    localparam logic [1:0] PSH_WORD = 2'd0;
    localparam logic [1:0] PSH_TOS  = 2'd1;
    localparam logic [1:0] PSH_IP   = 2'd2;
    localparam logic [1:0] PSH_LOC  = 2'd3;

    localparam logic [12:0] IP_ENTRY = 13'd4;

    typedef struct packed {
        logic       accept;
        logic       pm_wr;
        logic       sig_rd;
        logic [1:0] sig_idx;
        logic       ip_rd;
        logic       start_prog;
        logic       set_st;
        logic [2:0] st;
        logic       fault;
        logic       halt;
        logic       latch_op;
        logic       word_shift;
        logic       stk_rd;
        logic       latch_nos;
        logic       pop;
        logic       reload;
        logic       push;
        logic [1:0] push_sel;
        logic       alu_go;
        logic       div_start;
        logic       res_div;
        logic       wb;
        logic       sw1;
        logic       sw2;
        logic       jump;
        logic       loc_rd;
        logic       loc_wr;
        logic       set_sys;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] pdata;
        logic [7:0] op;
        logic       active;
        logic       ip_ok;
        logic       ip4_ok;
        logic       sp_zero;
        logic       sp_lt2;
        logic       sp_full;
        logic       sp_full2;
        logic       tos_zero;
        logic       tgt_ok;
        logic       idx_ok;
        logic       take;
        logic       div_done;
    } t_dp_stat;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = SIG0;
            2'd1:    v = SIG1;
            2'd2:    v = SIG2;
            default: v = SIG3;
        endcase
        return v;
    endfunction

    function automatic logic is_binop(input logic [7:0] op);
        return (op >= OP_ADD && op <= OP_MOD) || (op >= OP_CMP && op <= OP_LT);
    endfunction

endpackage

### sv/sbe_div.sv
// iterative signed 32-bit divider, one quotient bit per cycle
module sbe_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_mod,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_result
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic        r_neg_q, n_neg_q;
    logic        r_neg_r, n_neg_r;
    logic        r_mod, n_mod;
    logic [32:0] sh;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg_q = r_neg_q;
        n_neg_r = r_neg_r;
        n_mod   = r_mod;
        sh      = {r_rem[31:0], r_q[31]};
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = 5'd0;
            n_q     = i_num[31] ? 32'd0 - i_num : i_num;
            n_den   = i_den[31] ? 32'd0 - i_den : i_den;
            n_rem   = 33'd0;
            n_neg_q = i_num[31] ^ i_den[31];
            n_neg_r = i_num[31];
            n_mod   = i_is_mod;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = sh - {1'b0, r_den};
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = sh;
                n_q   = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_neg_q <= n_neg_q;
        r_neg_r <= n_neg_r;
        r_mod   <= n_mod;
    end

    assign o_done   = r_done;
    assign o_result = r_mod ? (r_neg_r ? 32'd0 - r_rem[31:0] : r_rem[31:0])
                            : (r_neg_q ? 32'd0 - r_q : r_q);
endmodule

### sv/sbe_ctrl.sv
// instruction sequencer state machine
module sbe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_kind,
    input  sbe_pkg::t_dp_stat i_stat,
    output sbe_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WRITE = 5'd1;
    localparam logic [4:0] S_SIG   = 5'd2;
    localparam logic [4:0] S_SIGCK = 5'd3;
    localparam logic [4:0] S_DEC   = 5'd4;
    localparam logic [4:0] S_WRD   = 5'd5;
    localparam logic [4:0] S_WSH   = 5'd6;
    localparam logic [4:0] S_OPX   = 5'd7;
    localparam logic [4:0] S_NOS   = 5'd8;
    localparam logic [4:0] S_ALU   = 5'd9;
    localparam logic [4:0] S_DIV   = 5'd10;
    localparam logic [4:0] S_WB    = 5'd11;
    localparam logic [4:0] S_SW1   = 5'd12;
    localparam logic [4:0] S_SW2   = 5'd13;
    localparam logic [4:0] S_RLD   = 5'd14;
    localparam logic [4:0] S_LX    = 5'd15;
    localparam logic [4:0] S_LD2   = 5'd16;
    localparam logic [4:0] S_DONE  = 5'd17;

    logic [4:0] r_state, n_state;
    logic [1:0] r_cnt, n_cnt;
    sbe_pkg::t_dp_cmd c;

    always_comb begin
        c       = '0;
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    c.accept = 1'b1;
                    case (i_kind)
                        sbe_pkg::KIND_WRITE: n_state = S_WRITE;
                        sbe_pkg::KIND_START: begin
                            n_cnt   = 2'd0;
                            n_state = S_SIG;
                        end
                        sbe_pkg::KIND_EXEC: begin
                            if (!i_stat.active) begin
                                c.set_st = 1'b1;
                                c.st     = sbe_pkg::ST_IDLE;
                                n_state  = S_DONE;
                            end else if (!i_stat.ip_ok) begin
                                c.fault = 1'b1;
                                n_state = S_DONE;
                            end else begin
                                c.ip_rd = 1'b1;
                                n_state = S_DEC;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_WRITE: begin
                c.pm_wr = 1'b1;
                n_state = S_DONE;
            end
            S_SIG: begin
                c.sig_rd  = 1'b1;
                c.sig_idx = r_cnt;
                n_state   = S_SIGCK;
            end
            S_SIGCK: begin
                if (i_stat.pdata != sbe_pkg::sig_byte(r_cnt)) begin
                    c.set_st = 1'b1;
                    c.st     = sbe_pkg::ST_BADSIG;
                    n_state  = S_DONE;
                end else if (r_cnt == 2'd3) begin
                    c.start_prog = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_SIG;
                end
            end
            S_DEC: begin
                c.latch_op = 1'b1;
                n_state    = S_DONE;
                n_cnt      = 2'd0;
                if (sbe_pkg::is_binop(i_stat.pdata) || i_stat.pdata == sbe_pkg::OP_SWAP) begin
                    if (i_stat.sp_lt2) c.fault = 1'b1;
                    else begin
                        c.stk_rd = 1'b1;
                        n_state  = S_NOS;
                    end
                end else begin
                    case (i_stat.pdata)
                        sbe_pkg::OP_HALT: begin
                            c.halt   = 1'b1;
                            c.set_st = 1'b1;
                            c.st     = sbe_pkg::ST_HALT;
                        end
                        sbe_pkg::OP_NOP, sbe_pkg::OP_BRK: ;
                        sbe_pkg::OP_PUSH, sbe_pkg::OP_CALL: begin
                            if (i_stat.ip4_ok) n_state = S_WRD;
                            else c.fault = 1'b1;
                        end
                        sbe_pkg::OP_JMP: begin
                            if (i_stat.ip4_ok) n_state = S_WRD;
                        end
                        sbe_pkg::OP_POP, sbe_pkg::OP_JZ, sbe_pkg::OP_JNZ,
                        sbe_pkg::OP_RET: begin
                            if (i_stat.sp_zero) c.fault = 1'b1;
                            else begin
                                c.pop   = 1'b1;
                                n_state = S_RLD;
                            end
                        end
                        sbe_pkg::OP_DUP: begin
                            if (i_stat.sp_zero || i_stat.sp_full) c.fault = 1'b1;
                            else begin
                                c.push     = 1'b1;
                                c.push_sel = sbe_pkg::PSH_TOS;
                            end
                        end
                        sbe_pkg::OP_LOAD, sbe_pkg::OP_STORE, sbe_pkg::OP_SYS: begin
                            if (i_stat.ip_ok) begin
                                c.ip_rd = 1'b1;
                                n_state = S_LX;
                            end
                        end
                        default: c.fault = 1'b1;
                    endcase
                end
            end
            S_WRD: begin
                c.ip_rd = 1'b1;
                n_cnt   = r_cnt + 2'd1;
                n_state = S_WSH;
            end
            S_WSH: begin
                c.word_shift = 1'b1;
                n_state      = (r_cnt == 2'd0) ? S_OPX : S_WRD;
            end
            S_OPX: begin
                n_state = S_DONE;
                case (i_stat.op)
                    sbe_pkg::OP_PUSH: begin
                        if (i_stat.sp_full) c.fault = 1'b1;
                        else begin
                            c.push     = 1'b1;
                            c.push_sel = sbe_pkg::PSH_WORD;
                        end
                    end
                    sbe_pkg::OP_JMP: begin
                        if (i_stat.tgt_ok) c.jump = 1'b1;
                        else c.fault = 1'b1;
                    end
                    sbe_pkg::OP_JZ, sbe_pkg::OP_JNZ: begin
                        if (i_stat.take) begin
                            if (i_stat.tgt_ok) c.jump = 1'b1;
                            else c.fault = 1'b1;
                        end
                    end
                    sbe_pkg::OP_CALL: begin
                        if (i_stat.sp_full2) c.fault = 1'b1;
                        else begin
                            // return address is pushed even when the target is bad
                            c.push     = 1'b1;
                            c.push_sel = sbe_pkg::PSH_IP;
                            if (i_stat.tgt_ok) c.jump = 1'b1;
                            else c.fault = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_NOS: begin
                c.latch_nos = 1'b1;
                n_state     = (i_stat.op == sbe_pkg::OP_SWAP) ? S_SW1 : S_ALU;
            end
            S_ALU: begin
                if (i_stat.op == sbe_pkg::OP_DIV || i_stat.op == sbe_pkg::OP_MOD) begin
                    if (i_stat.tos_zero) begin
                        c.fault = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        c.div_start = 1'b1;
                        n_state     = S_DIV;
                    end
                end else begin
                    c.alu_go = 1'b1;
                    n_state  = S_WB;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    c.res_div = 1'b1;
                    n_state   = S_WB;
                end
            end
            S_WB: begin
                c.wb    = 1'b1;
                n_state = S_DONE;
            end
            S_SW1: begin
                c.sw1   = 1'b1;
                n_state = S_SW2;
            end
            S_SW2: begin
                c.sw2   = 1'b1;
                n_state = S_DONE;
            end
            S_RLD: begin
                c.reload = 1'b1;
                n_state  = S_DONE;
                n_cnt    = 2'd0;
                case (i_stat.op)
                    sbe_pkg::OP_JZ, sbe_pkg::OP_JNZ: begin
                        if (i_stat.ip4_ok) n_state = S_WRD;
                        else c.fault = 1'b1;
                    end
                    sbe_pkg::OP_RET: begin
                        if (i_stat.tgt_ok) c.jump = 1'b1;
                        else c.fault = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_LX: begin
                n_state = S_DONE;
                case (i_stat.op)
                    sbe_pkg::OP_LOAD: begin
                        if (!i_stat.idx_ok || i_stat.sp_full) c.fault = 1'b1;
                        else begin
                            c.loc_rd = 1'b1;
                            n_state  = S_LD2;
                        end
                    end
                    sbe_pkg::OP_STORE: begin
                        if (!i_stat.idx_ok || i_stat.sp_zero) c.fault = 1'b1;
                        else begin
                            c.loc_wr = 1'b1;
                            c.pop    = 1'b1;
                            n_state  = S_RLD;
                        end
                    end
                    default: begin
                        c.set_sys = 1'b1;
                        c.set_st  = 1'b1;
                        c.st      = sbe_pkg::ST_SYSCALL;
                    end
                endcase
            end
            S_LD2: begin
                c.push     = 1'b1;
                c.push_sel = sbe_pkg::PSH_LOC;
                n_state    = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_cmd  = c;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);
endmodule

### sv/sbe_datapath.sv
// machine registers, program, stack and local memories, alu
module sbe_datapath #(
    parameter int PROGRAM_BYTES = 4096,
    parameter int STACK_DEPTH   = 64,
    parameter int LOCAL_SLOTS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [12:0]          i_cfg_wdata,
    input  logic [11:0]          i_prog_addr,
    input  logic [7:0]           i_prog_byte,
    input  sbe_pkg::t_dp_cmd     i_cmd,
    output sbe_pkg::t_dp_stat    o_stat,
    output logic [2:0]           o_status,
    output logic                 o_running,
    output logic                 o_fault,
    output logic [12:0]          o_ip,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_sp,
    output logic [31:0]          o_top,
    output logic [7:0]           o_sysid
);
    localparam int AW  = $clog2(PROGRAM_BYTES);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH+1);
    localparam int LAW = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

    logic [7:0]  pmem [PROGRAM_BYTES];
    logic [31:0] smem [STACK_DEPTH];
    logic [31:0] lmem [LOCAL_SLOTS];

    logic [12:0]      r_psize;
    logic [11:0]      r_waddr;
    logic [7:0]       r_wbyte;
    logic [7:0]       r_pdata;
    logic [7:0]       r_op;
    logic [12:0]      r_ip, n_ip;
    logic [SPW-1:0]   r_sp, n_sp;
    logic [31:0]      r_tos, n_tos;
    logic [31:0]      r_nos;
    logic [31:0]      r_word;
    logic [31:0]      r_res;
    logic [31:0]      r_sq;
    logic [31:0]      r_lq;
    logic             r_lv;
    logic             r_cond;
    logic [LOCAL_SLOTS-1:0] r_lvalid;
    logic             r_active, r_fault;
    logic [2:0]       r_status, n_status;
    logic [7:0]       r_sysid;

    logic [12:0]      size;
    logic [31:0]      alu;
    logic [31:0]      push_val;
    logic             div_done;
    logic [31:0]      div_res;
    logic [SAW-1:0]   sa_nos;
    logic [LAW-1:0]   la;

    assign size   = (32'(r_psize) < PROGRAM_BYTES) ? r_psize : 13'(PROGRAM_BYTES);
    assign sa_nos = SAW'(r_sp - SPW'(2));
    assign la     = LAW'(r_pdata);

    // program store
    always_ff @(posedge i_clk) begin
        if (i_cmd.pm_wr && 32'(r_waddr) < PROGRAM_BYTES) pmem[AW'(r_waddr)] <= r_wbyte;
        if (i_cmd.sig_rd) r_pdata <= pmem[AW'(i_cmd.sig_idx)];
        else if (i_cmd.ip_rd) r_pdata <= pmem[AW'(r_ip)];
    end

    // operand stack, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) smem[SAW'(r_sp)] <= push_val;
        else if (i_cmd.wb) smem[sa_nos] <= r_res;
        else if (i_cmd.sw1) smem[sa_nos] <= r_tos;
        else if (i_cmd.sw2) smem[SAW'(r_sp - SPW'(1))] <= r_nos;
        if (i_cmd.stk_rd || i_cmd.pop) r_sq <= smem[sa_nos];
    end

    // locals
    always_ff @(posedge i_clk) begin
        if (i_cmd.loc_wr) lmem[la] <= r_tos;
        if (i_cmd.loc_rd) begin
            r_lq <= lmem[la];
            r_lv <= r_lvalid[la];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_lvalid <= '0;
        else if (i_cmd.start_prog) r_lvalid <= '0;
        else if (i_cmd.loc_wr) r_lvalid[la] <= 1'b1;
    end

    always_comb begin
        case (i_cmd.push_sel)
            sbe_pkg::PSH_WORD: push_val = r_word;
            sbe_pkg::PSH_TOS:  push_val = r_tos;
            sbe_pkg::PSH_IP:   push_val = 32'(r_ip);
            default:           push_val = r_lv ? r_lq : 32'd0;
        endcase
    end

    always_comb begin
        case (r_op)
            sbe_pkg::OP_ADD: alu = r_nos + r_tos;
            sbe_pkg::OP_SUB: alu = r_nos - r_tos;
            sbe_pkg::OP_MUL: alu = r_nos * r_tos;
            sbe_pkg::OP_CMP: alu = ($signed(r_nos) < $signed(r_tos)) ? 32'hFFFF_FFFF :
                                   ((r_nos == r_tos) ? 32'd0 : 32'd1);
            sbe_pkg::OP_EQ:  alu = 32'(r_nos == r_tos);
            sbe_pkg::OP_NEQ: alu = 32'(r_nos != r_tos);
            sbe_pkg::OP_GT:  alu = 32'($signed(r_tos) < $signed(r_nos));
            default:         alu = 32'($signed(r_nos) < $signed(r_tos));
        endcase
    end

    sbe_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.div_start),
        .i_is_mod (r_op == sbe_pkg::OP_MOD),
        .i_num    (r_nos),
        .i_den    (r_tos),
        .o_done   (div_done),
        .o_result (div_res)
    );

    always_comb begin
        n_ip = r_ip;
        if (i_cmd.start_prog) n_ip = sbe_pkg::IP_ENTRY;
        else if (i_cmd.jump) n_ip = r_word[12:0];
        else if (i_cmd.ip_rd) n_ip = r_ip + 13'd1;

        n_sp = r_sp;
        if (i_cmd.start_prog) n_sp = '0;
        else if (i_cmd.push) n_sp = r_sp + SPW'(1);
        else if (i_cmd.pop || i_cmd.wb) n_sp = r_sp - SPW'(1);

        n_tos = r_tos;
        if (i_cmd.push) n_tos = push_val;
        else if (i_cmd.reload) n_tos = r_sq;
        else if (i_cmd.wb) n_tos = r_res;
        else if (i_cmd.sw2) n_tos = r_nos;

        n_status = r_status;
        if (i_cmd.accept) n_status = sbe_pkg::ST_OK;
        if (i_cmd.set_st) n_status = i_cmd.st;
        if (i_cmd.fault) n_status = sbe_pkg::ST_FAULT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psize  <= 13'd0;
            r_ip     <= 13'd0;
            r_sp     <= '0;
            r_active <= 1'b0;
            r_fault  <= 1'b0;
            r_status <= sbe_pkg::ST_OK;
            r_sysid  <= 8'd0;
        end else begin
            if (i_cfg_we) r_psize <= i_cfg_wdata;
            r_ip     <= n_ip;
            r_sp     <= n_sp;
            r_status <= n_status;
            if (i_cmd.start_prog) begin
                r_active <= 1'b1;
                r_fault  <= 1'b0;
            end else if (i_cmd.fault) begin
                r_active <= 1'b0;
                r_fault  <= 1'b1;
            end else if (i_cmd.halt) begin
                r_active <= 1'b0;
                r_fault  <= 1'b0;
            end
            if (i_cmd.accept) r_sysid <= 8'd0;
            else if (i_cmd.set_sys) r_sysid <= r_pdata;
        end
        r_tos <= n_tos;
        if (i_cmd.accept) begin
            r_waddr <= i_prog_addr;
            r_wbyte <= i_prog_byte;
        end
        if (i_cmd.latch_op) r_op <= r_pdata;
        if (i_cmd.latch_nos) r_nos <= r_sq;
        if (i_cmd.word_shift) r_word <= {r_word[23:0], r_pdata};
        else if (i_cmd.pop) r_word <= r_tos;
        if (i_cmd.pop) r_cond <= (r_tos == 32'd0);
        if (i_cmd.alu_go) r_res <= alu;
        else if (i_cmd.res_div) r_res <= div_res;
    end

    always_comb begin
        o_stat          = '0;
        o_stat.pdata    = r_pdata;
        o_stat.op       = r_op;
        o_stat.active   = r_active;
        o_stat.ip_ok    = r_ip < size;
        o_stat.ip4_ok   = ({1'b0, r_ip} + 14'd3) < {1'b0, size};
        o_stat.sp_zero  = (r_sp == '0);
        o_stat.sp_lt2   = (32'(r_sp) < 32'd2);
        o_stat.sp_full  = (32'(r_sp) >= STACK_DEPTH);
        o_stat.sp_full2 = (32'(r_sp) + 32'd1 >= STACK_DEPTH);
        o_stat.tos_zero = (r_tos == 32'd0);
        o_stat.tgt_ok   = (r_word >= 32'd4) && (r_word < 32'(size));
        o_stat.idx_ok   = (32'(r_pdata) < LOCAL_SLOTS);
        o_stat.take     = ((r_op == sbe_pkg::OP_JZ) == r_cond);
        o_stat.div_done = div_done;
    end

    assign o_status  = r_status;
    assign o_running = r_active;
    assign o_fault   = r_fault;
    assign o_ip      = r_ip;
    assign o_sp      = r_sp;
    assign o_top     = (r_sp != '0) ? r_tos : 32'd0;
    assign o_sysid   = r_sysid;
endmodule

### sv/stack_bytecode_executor_unit.sv
// top level of the stack bytecode executor
//
// a single-process 32-bit stack machine driven one command at a time
// commands: start high while busy is low transfers one item (kind, address, byte)
//   kind 0 writes one program byte, kind 1 checks the signature and starts,
//   kind 2 executes one instruction, kind 3 does nothing
// every command gives exactly one result: o_valid is high for one cycle and
//   the result fields are valid in that cycle; the receiver cannot stall
// program size is written through i_cfg_we / i_cfg_wdata; the user must do so while idle, the block does not enforce it
// the next command is taken the cycle after o_valid; the program store read
//   port gives one byte per access and the divider one quotient bit per cycle
// reset clears the ip, sp, status, size and flag registers and the local valid bits;
//   program and stack memories hold garbage until written, no clearing pass is needed
module stack_bytecode_executor_unit #(
    parameter int PROGRAM_BYTES = 4096,
    parameter int STACK_DEPTH   = 64,
    parameter int LOCAL_SLOTS   = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [12:0]                       i_cfg_wdata,
    input  logic [1:0]                        i_kind,
    input  logic [11:0]                       i_prog_addr,
    input  logic [7:0]                        i_prog_byte,
    output logic                              o_valid,
    output logic [2:0]                        o_status,
    output logic                              o_running,
    output logic signed [0:0]                 o_exit_value,
    output logic [12:0]                       o_instr_pointer,
    output logic [$clog2(STACK_DEPTH+1)-1:0]  o_stack_depth,
    output logic signed [31:0]                o_top_value,
    output logic [7:0]                        o_syscall_number
);
    sbe_pkg::t_dp_cmd  cmd;
    sbe_pkg::t_dp_stat stat;
    logic              fault;
    logic [31:0]       top;

    // sequencer: decodes opcodes and steps the datapath
    sbe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    // machine state and memories
    sbe_datapath #(
        .PROGRAM_BYTES (PROGRAM_BYTES),
        .STACK_DEPTH   (STACK_DEPTH),
        .LOCAL_SLOTS   (LOCAL_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_prog_addr (i_prog_addr),
        .i_prog_byte (i_prog_byte),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (o_status),
        .o_running   (o_running),
        .o_fault     (fault),
        .o_ip        (o_instr_pointer),
        .o_sp        (o_stack_depth),
        .o_top       (top),
        .o_sysid     (o_syscall_number)
    );

    // exit code -1 is a single set bit
    assign o_exit_value = fault;
    assign o_top_value  = top;

    // a result only shows while the command is still held busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy) else $error("result strobe outside a command");

    // a transfer always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer not taken");

    // a running machine never carries a fault exit code
    a_run_nofault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_running |-> (o_exit_value == 1'sb0)) else $error("running with fault");

    // stack depth stays within the stack
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_stack_depth) <= STACK_DEPTH) else $error("stack depth overrun");
endmodule

### sim/stack_bytecode_executor_unit_tb.sv
// testbench of the stack bytecode executor: random bytecode programs checked against a predictor
`timescale 1ns / 100ps

module stack_bytecode_executor_unit_tb;
    import sbe_pkg::*;

    localparam int PM_BYTES   = 4096;
    localparam int STK_DEPTH  = 64;
    localparam int LOC_SLOTS  = 16;
    localparam int STALL_LIMIT = 4000;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [7:0] OP_ABS_LD = 8'h44;
    localparam logic [7:0] OP_ABS_ST = 8'h45;

    typedef struct packed {
        logic [2:0]  status;
        logic        running;
        logic        exit_value;
        logic [12:0] ip;
        logic [6:0]  depth;
        logic [31:0] top;
        logic [7:0]  sys_id;
    } step_result_t;

    // machine model plus the queue of results it predicts
    class machine_scoreboard;
        logic [7:0]   pm [PM_BYTES];
        logic [31:0]  stk [STK_DEPTH];
        logic [31:0]  loc [LOC_SLOTS];
        int           ip_q;
        int           sp_q;
        bit           active;
        bit           faulted;
        int           size_reg;
        int           errors;
        step_result_t expected_results [$];

        function new();
            foreach (loc[i]) loc[i] = '0;
            ip_q = 0; sp_q = 0; active = 0; faulted = 0; size_reg = 0; errors = 0;
        endfunction

        function int eff_size();
            return (size_reg < PM_BYTES) ? size_reg : PM_BYTES;
        endfunction

        function logic [2:0] stop_fault();
            active = 0;
            faulted = 1;
            return ST_FAULT;
        endfunction

        function logic [31:0] word_at(int at);
            return {pm[at], pm[at+1], pm[at+2], pm[at+3]};
        endfunction

        function bit target_bad(logic [31:0] t);
            return (t < 4) || (t >= eff_size());
        endfunction

        function logic [31:0] magn(logic [31:0] v);
            return v[31] ? -v : v;
        endfunction

        function logic [2:0] run_instr(output logic [7:0] sys_id);
            int size;
            logic [7:0]  op;
            logic [31:0] a, b, r, q, m, t;
            size = eff_size();
            sys_id = '0;
            if (ip_q >= size) return stop_fault();
            op = pm[ip_q];
            ip_q++;
            if (is_binop(op)) begin
                if (sp_q < 2) return stop_fault();
                b = stk[sp_q-1];
                a = stk[sp_q-2];
                case (op)
                    OP_ADD: r = a + b;
                    OP_SUB: r = a - b;
                    OP_MUL: r = a * b;
                    OP_DIV, OP_MOD: begin
                        if (b == 0) return stop_fault();
                        q = magn(a) / magn(b);
                        m = magn(a) % magn(b);
                        if (op == OP_DIV) r = (a[31] ^ b[31]) ? -q : q;
                        else r = a[31] ? -m : m;
                    end
                    OP_CMP: r = ($signed(a) < $signed(b)) ? 32'hFFFF_FFFF : ((a == b) ? 0 : 1);
                    OP_EQ:  r = (a == b);
                    OP_NEQ: r = (a != b);
                    OP_GT:  r = ($signed(b) < $signed(a));
                    default: r = ($signed(a) < $signed(b));
                endcase
                stk[sp_q-2] = r;
                sp_q--;
                return ST_OK;
            end
            case (op)
                OP_HALT: begin
                    active = 0;
                    faulted = 0;
                    return ST_HALT;
                end
                OP_NOP, OP_BRK: return ST_OK;
                OP_PUSH: begin
                    if (ip_q + 3 >= size) return stop_fault();
                    r = word_at(ip_q);
                    ip_q += 4;
                    if (sp_q >= STK_DEPTH) return stop_fault();
                    stk[sp_q++] = r;
                    return ST_OK;
                end
                OP_POP: begin
                    if (sp_q == 0) return stop_fault();
                    sp_q--;
                    return ST_OK;
                end
                OP_DUP: begin
                    if (sp_q == 0 || sp_q >= STK_DEPTH) return stop_fault();
                    stk[sp_q] = stk[sp_q-1];
                    sp_q++;
                    return ST_OK;
                end
                OP_SWAP: begin
                    if (sp_q < 2) return stop_fault();
                    r = stk[sp_q-1];
                    stk[sp_q-1] = stk[sp_q-2];
                    stk[sp_q-2] = r;
                    return ST_OK;
                end
                OP_JMP: begin
                    // short operand: nothing further happens
                    if (ip_q + 3 < size) begin
                        t = word_at(ip_q);
                        ip_q += 4;
                        if (target_bad(t)) return stop_fault();
                        ip_q = t;
                    end
                    return ST_OK;
                end
                OP_JZ, OP_JNZ: begin
                    if (sp_q == 0) return stop_fault();
                    r = stk[--sp_q];
                    if (ip_q + 3 >= size) return stop_fault();
                    t = word_at(ip_q);
                    ip_q += 4;
                    if ((op == OP_JZ) == (r == 0)) begin
                        if (target_bad(t)) return stop_fault();
                        ip_q = t;
                    end
                    return ST_OK;
                end
                OP_CALL: begin
                    if (ip_q + 3 >= size) return stop_fault();
                    t = word_at(ip_q);
                    ip_q += 4;
                    if (sp_q + 1 >= STK_DEPTH) return stop_fault();
                    stk[sp_q++] = ip_q;
                    if (target_bad(t)) return stop_fault();
                    ip_q = t;
                    return ST_OK;
                end
                OP_RET: begin
                    if (sp_q == 0) return stop_fault();
                    t = stk[--sp_q];
                    if (target_bad(t)) return stop_fault();
                    ip_q = t;
                    return ST_OK;
                end
                OP_LOAD: begin
                    if (ip_q < size) begin
                        a = pm[ip_q++];
                        if (a >= LOC_SLOTS || sp_q >= STK_DEPTH) return stop_fault();
                        stk[sp_q++] = loc[a];
                    end
                    return ST_OK;
                end
                OP_STORE: begin
                    if (ip_q < size) begin
                        a = pm[ip_q++];
                        if (a >= LOC_SLOTS || sp_q == 0) return stop_fault();
                        loc[a] = stk[--sp_q];
                    end
                    return ST_OK;
                end
                OP_SYS: begin
                    if (ip_q < size) begin
                        sys_id = pm[ip_q++];
                        return ST_SYSCALL;
                    end
                    return ST_OK;
                end
                default: return stop_fault();
            endcase
        endfunction

        // accepted input transfer: predict its result
        function void note_command(logic [1:0] kind, logic [11:0] addr, logic [7:0] data);
            step_result_t res;
            logic [7:0] sys_id;
            res = '0;
            sys_id = '0;
            res.status = ST_OK;
            if (kind == KIND_WRITE) begin
                pm[addr] = data;
            end else if (kind == KIND_START) begin
                if (pm[0] != SIG0 || pm[1] != SIG1 || pm[2] != SIG2 || pm[3] != SIG3) begin
                    res.status = ST_BADSIG;
                end else begin
                    ip_q = 4;
                    sp_q = 0;
                    foreach (loc[i]) loc[i] = '0;
                    active = 1;
                    faulted = 0;
                end
            end else if (kind == KIND_EXEC) begin
                if (!active) res.status = ST_IDLE;
                else res.status = run_instr(sys_id);
            end
            res.running    = active;
            res.exit_value = faulted;
            res.ip         = ip_q[12:0];
            res.depth      = sp_q[6:0];
            res.top        = (sp_q > 0) ? stk[sp_q-1] : '0;
            res.sys_id     = (res.status == ST_SYSCALL) ? sys_id : '0;
            expected_results.push_back(res);
        endfunction

        function void check_result(step_result_t got);
            step_result_t exp;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
            end
            if (got.running !== exp.running) begin
                $error("running: expected %0d, got %0d", exp.running, got.running); errors++;
            end
            if (got.exit_value !== exp.exit_value) begin
                $error("exit_value: expected %0d, got %0d", exp.exit_value, got.exit_value);
                errors++;
            end
            if (got.ip !== exp.ip) begin
                $error("instr_pointer: expected %0d, got %0d", exp.ip, got.ip); errors++;
            end
            if (got.depth !== exp.depth) begin
                $error("stack_depth: expected %0d, got %0d", exp.depth, got.depth); errors++;
            end
            if (got.top !== exp.top) begin
                $error("top_value: expected %h, got %h", exp.top, got.top); errors++;
            end
            if (got.sys_id !== exp.sys_id) begin
                $error("syscall_number: expected %0d, got %0d", exp.sys_id, got.sys_id);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_we;
    logic [12:0] i_cfg_wdata;
    logic [1:0]  i_kind;
    logic [11:0] i_prog_addr;
    logic [7:0]  i_prog_byte;
    logic        o_valid;
    logic [2:0]  o_status;
    logic        o_running;
    logic signed [0:0] o_exit_value;
    logic [12:0] o_instr_pointer;
    logic [6:0]  o_stack_depth;
    logic signed [31:0] o_top_value;
    logic [7:0]  o_syscall_number;

    machine_scoreboard sb;
    int  idle_cycles;
    int  item_count;
    logic [7:0] prog_bytes [$];

    stack_bytecode_executor_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_kind           (i_kind),
        .i_prog_addr      (i_prog_addr),
        .i_prog_byte      (i_prog_byte),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_running        (o_running),
        .o_exit_value     (o_exit_value),
        .o_instr_pointer  (o_instr_pointer),
        .o_stack_depth    (o_stack_depth),
        .o_top_value      (o_top_value),
        .o_syscall_number (o_syscall_number)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // result monitor: a result is valid for exactly one cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            sb.check_result({o_status, o_running, o_exit_value[0], o_instr_pointer,
                             o_stack_depth, o_top_value, o_syscall_number});
        end
    end

    // watchdog: cycles with neither an input transfer nor a result
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("stack_bytecode_executor_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // mostly short gaps, a few long ones, often none at all
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    // one command transfer; start stays high across back-to-back transfers
    task automatic send_cmd(input logic [1:0] kind, input logic [11:0] addr,
                            input logic [7:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_kind      <= kind;
        i_prog_addr <= addr;
        i_prog_byte <= data;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(kind, addr, data);
        item_count++;
    endtask

    // size register write, only with the machine quiet
    task automatic write_size(input logic [12:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.size_reg = value;
    endtask

    task automatic write_program(input int base);
        foreach (prog_bytes[i]) send_cmd(KIND_WRITE, 12'(base + i), prog_bytes[i]);
    endtask

    function automatic void add_word(logic [31:0] w);
        prog_bytes.push_back(w[31:24]);
        prog_bytes.push_back(w[23:16]);
        prog_bytes.push_back(w[15:8]);
        prog_bytes.push_back(w[7:0]);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 9);
            default: return $urandom;
        endcase
    endfunction

    // jump target, mostly inside the program
    function automatic logic [31:0] pick_target(int lim);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom;
        if (r == 1 || lim <= 4) return $urandom_range(0, 4);
        if (r == 2) return lim;
        return $urandom_range(4, lim - 1);
    endfunction

    // random but mostly well-formed instruction stream
    task automatic build_program(input int max_len, input int lim);
        logic [7:0] ops [] = '{OP_HALT, OP_NOP, OP_PUSH, OP_POP, OP_DUP, OP_SWAP, OP_ADD,
                               OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_CMP, OP_EQ, OP_NEQ, OP_GT,
                               OP_LT, OP_JMP, OP_JZ, OP_JNZ, OP_CALL, OP_RET, OP_LOAD,
                               OP_STORE, OP_SYS, OP_BRK, OP_ABS_LD, OP_ABS_ST};
        logic [7:0] op;
        int r;
        prog_bytes.delete();
        while (prog_bytes.size() < max_len) begin
            r = $urandom_range(0, 99);
            if (r < 25) op = OP_PUSH;
            else if (r < 27) op = 8'($urandom);
            else if (r < 29) begin
                // dup run to push past the top of the stack
                prog_bytes.push_back(OP_PUSH);
                add_word(pick_value());
                repeat (66) prog_bytes.push_back(OP_DUP);
                continue;
            end else begin
                op = ops[$urandom_range(0, ops.size() - 1)];
                if (op == OP_HALT && $urandom_range(0, 3) != 0) op = OP_NOP;
            end
            prog_bytes.push_back(op);
            case (op)
                OP_PUSH: add_word(pick_value());
                OP_JMP, OP_JZ, OP_JNZ, OP_CALL: add_word(pick_target(lim));
                OP_LOAD, OP_STORE:
                    prog_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                                       : 8'($urandom_range(0, 15)));
                OP_SYS: prog_bytes.push_back(8'($urandom));
                default: ;
            endcase
        end
        while (prog_bytes.size() > max_len) void'(prog_bytes.pop_back());
    endtask

    task automatic run_steps(input int n);
        repeat (n) begin
            send_cmd(KIND_EXEC, 12'($urandom), 8'($urandom));
            if (!sb.active && $urandom_range(0, 2) != 0) break;
        end
    endtask

    initial begin
        int size_sel, lim, plen;
        sb = new();
        item_count  = 0;
        idle_cycles = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_kind      <= KIND_WRITE;
        i_prog_addr <= '0;
        i_prog_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every store byte gets a value so that no fetch sees an unwritten byte
        for (int a = 0; a < PM_BYTES; a++) send_cmd(KIND_WRITE, 12'(a), 8'($urandom));

        // directed: unused kind, execute while stopped, start with a bad signature
        send_cmd(KIND_NONE, 12'hFFF, 8'hFF);
        send_cmd(KIND_EXEC, 12'h000, 8'h00);
        send_cmd(KIND_WRITE, 12'd0, 8'h4F);
        send_cmd(KIND_START, 12'd0, 8'h00);
        send_cmd(KIND_WRITE, 12'd0, SIG0);
        send_cmd(KIND_WRITE, 12'd1, SIG1);
        send_cmd(KIND_WRITE, 12'd2, SIG2);
        send_cmd(KIND_WRITE, 12'd3, SIG3);
        // size zero: the first fetch faults
        send_cmd(KIND_START, 12'd0, 8'h00);
        send_cmd(KIND_EXEC, 12'd0, 8'h00);

        // most-negative over -1, its remainder, a syscall, a local round trip,
        // then a modulo by zero that the steps run here do not reach
        write_size(13'd64);
        prog_bytes.delete();
        prog_bytes.push_back(OP_PUSH); add_word(32'h8000_0000);
        prog_bytes.push_back(OP_PUSH); add_word(32'hFFFF_FFFF);
        prog_bytes.push_back(OP_DIV);
        prog_bytes.push_back(OP_PUSH); add_word(32'hFFFF_FFFF);
        prog_bytes.push_back(OP_MOD);
        prog_bytes.push_back(OP_SYS);   prog_bytes.push_back(8'hFF);
        prog_bytes.push_back(OP_STORE); prog_bytes.push_back(8'd15);
        prog_bytes.push_back(OP_LOAD);  prog_bytes.push_back(8'd15);
        prog_bytes.push_back(OP_DUP);
        prog_bytes.push_back(OP_MOD);
        write_program(4);
        send_cmd(KIND_START, 12'd0, 8'h00);
        run_steps(9);

        // random phases, each with its own program size
        while (item_count < PM_BYTES + 1100) begin
            size_sel = $urandom_range(0, 19);
            case (size_sel)
                0: lim = 0;
                1: lim = 4;
                2: lim = 5;
                3: lim = 4096;
                4: lim = 8191;
                default: lim = $urandom_range(8, 160);
            endcase
            write_size(13'(lim));
            lim = (lim < PM_BYTES) ? lim : PM_BYTES;
            plen = (lim > 4) ? lim - 4 : 0;
            if (plen > 120) plen = $urandom_range(20, 120);
            build_program(plen, lim);
            write_program(4);
            repeat ($urandom_range(1, 3)) begin
                send_cmd(KIND_START, 12'd0, 8'h00);
                run_steps($urandom_range(10, 60));
                // noise between runs
                case ($urandom_range(0, 5))
                    0: send_cmd(KIND_NONE, 12'($urandom), 8'($urandom));
                    1: send_cmd(KIND_WRITE, 12'($urandom_range(4, 4095)), 8'($urandom));
                    2: begin
                        send_cmd(KIND_WRITE, 12'($urandom_range(0, 3)), 8'($urandom));
                        send_cmd(KIND_START, 12'd0, 8'h00);
                        send_cmd(KIND_WRITE, 12'd0, SIG0);
                        send_cmd(KIND_WRITE, 12'd1, SIG1);
                        send_cmd(KIND_WRITE, 12'd2, SIG2);
                        send_cmd(KIND_WRITE, 12'd3, SIG3);
                    end
                    default: send_cmd(KIND_EXEC, 12'($urandom), 8'($urandom));
                endcase
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("stack_bytecode_executor_unit_tb: PASS");
        end else begin
            $display("stack_bytecode_executor_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
